FILE: hdl/plrd_pkg.sv
// ----------------------------------------------------------------------------
// plrd_pkg: shared types and constants of the player list reply deframer
// Result kinds, framing phases, the configuration bundle and the result word.
// ----------------------------------------------------------------------------
package plrd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KindW    = 3;
  localparam int unsigned OffsetW  = 5;
  localparam int unsigned TypeW    = 2;
  localparam int unsigned PortW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MaxRes   = 3;
  localparam int unsigned ResCntW  = 2;
  localparam int unsigned MDataW   = 24;

  // entry lengths: type byte + address (+ port)
  localparam logic [OffsetW-1:0] LenTypeByte = 5'd1;
  localparam logic [OffsetW-1:0] LenAddrV4   = 5'd4;
  localparam logic [OffsetW-1:0] LenAddrV6   = 5'd16;
  localparam logic [OffsetW-1:0] LenPort     = 5'd2;
  localparam logic [ByteW-1:0]   MaxAddrType = 8'd3;

  typedef enum logic [KindW-1:0] {
    KIND_ENTRY   = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_BADTYPE = 3'd2,
    KIND_REPLY   = 3'd3,
    KIND_BADOP   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_COUNT  = 2'd1,
    PH_ENTRY  = 2'd2,
    PH_DROP   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    PEND_NONE     = 2'd0,
    PEND_PORT_EXT = 2'd1,
    PEND_LIST     = 2'd2
  } pend_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OP_PORT_EXT    = 2'd0,
    REG_OP_PLAYER_LIST = 2'd1,
    REG_LOCAL_PORT     = 2'd2,
    REG_LISTENER       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] op_port_ext;
    logic [ByteW-1:0] op_player_list;
    logic [PortW-1:0] local_port;
    logic             listen;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   payload;
    logic [ByteW-1:0]   entry_index;
    logic [OffsetW-1:0] entry_offset;
    logic [TypeW-1:0]   entry_type;
  } result_t;

  localparam result_t ResultZero = '{kind: KIND_ENTRY, payload: '0, entry_index: '0,
                                     entry_offset: '0, entry_type: '0};

endpackage

FILE: hdl/plrd_cfg_regs.sv
// ----------------------------------------------------------------------------
// plrd_cfg_regs: configuration register file
// Holds the opcode values, the advertised port and the listener flag.
// ----------------------------------------------------------------------------
module plrd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [plrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [plrd_pkg::PortW-1:0]    cfg_data_i,
  output plrd_pkg::cfg_t                cfg_o
);
  import plrd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_OP_PORT_EXT:    cfg_d.op_port_ext    = cfg_data_i[ByteW-1:0];
        REG_OP_PLAYER_LIST: cfg_d.op_player_list = cfg_data_i[ByteW-1:0];
        REG_LOCAL_PORT:     cfg_d.local_port     = cfg_data_i;
        REG_LISTENER:       cfg_d.listen         = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{op_port_ext: 8'd0, op_player_list: 8'd1, local_port: '0, listen: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/plrd_frame_core.sv
// ----------------------------------------------------------------------------
// plrd_frame_core: message framing state and result generation
// Decodes one byte against the framing state, produces up to three results
// and advances the state when the byte is taken.
// ----------------------------------------------------------------------------
module plrd_frame_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  plrd_pkg::cfg_t                cfg_i,
  input  logic [plrd_pkg::ByteW-1:0]    byte_i,
  input  logic                          last_i,
  input  logic                          take_i,
  output plrd_pkg::result_t             res_o [plrd_pkg::MaxRes],
  output logic [plrd_pkg::ResCntW-1:0]  res_cnt_o
);
  import plrd_pkg::*;

  phase_e             phase_q, phase_d;
  pend_e              pend_q, pend_d;
  logic [ByteW-1:0]   left_q, left_d;
  logic [ByteW-1:0]   num_q, num_d;
  logic [OffsetW-1:0] pos_q, pos_d;
  logic [OffsetW-1:0] len_q, len_d;
  logic [TypeW-1:0]   type_q, type_d;

  logic [TypeW-1:0]   cur_type;
  logic [OffsetW-1:0] cur_len;
  logic [OffsetW-1:0] pos_inc;
  logic [ByteW-1:0]   left_dec;
  logic               is_v4, port_present;

  always_comb begin
    is_v4        = (byte_i == 8'd1) || (byte_i == 8'd2);
    port_present = (byte_i == 8'd2) || (byte_i == 8'd3);
    cur_type = (pos_q == '0) ? byte_i[TypeW-1:0] : type_q;
    cur_len  = (pos_q == '0) ?
               LenTypeByte + (is_v4 ? LenAddrV4 : LenAddrV6) + (port_present ? LenPort : '0) :
               len_q;
    pos_inc  = pos_q + OffsetW'(1);
    left_dec = left_q - ByteW'(1);
  end

  always_comb begin
    phase_d = phase_q;
    pend_d  = pend_q;
    left_d  = left_q;
    num_d   = num_q;
    pos_d   = pos_q;
    len_d   = len_q;
    type_d  = type_q;
    for (int i = 0; i < MaxRes; i++) begin
      res_o[i] = ResultZero;
    end
    res_cnt_o = '0;

    case (phase_q)
      PH_OPCODE: begin
        if (byte_i == cfg_i.op_port_ext) begin
          pend_d  = PEND_PORT_EXT;
          phase_d = PH_COUNT;
        end else if (byte_i == cfg_i.op_player_list) begin
          pend_d  = PEND_LIST;
          phase_d = PH_COUNT;
        end else begin
          res_o[0].kind = KIND_BADOP;
          res_cnt_o     = 2'd1;
          pend_d        = PEND_NONE;
          phase_d       = last_i ? PH_OPCODE : PH_DROP;
        end
      end
      PH_COUNT: begin
        if (pend_q == PEND_PORT_EXT) begin
          if (byte_i != '0) begin
            res_o[0].kind    = KIND_REPLY;
            res_o[0].payload = cfg_i.op_port_ext;
            res_o[1].kind    = KIND_REPLY;
            res_o[1].payload = cfg_i.local_port[PortW-1:ByteW];
            res_o[2].kind    = KIND_REPLY;
            res_o[2].payload = cfg_i.local_port[ByteW-1:0];
            res_cnt_o        = 2'd3;
          end
          phase_d = PH_OPCODE;
          pend_d  = PEND_NONE;
        end else begin
          left_d = byte_i;
          num_d  = '0;
          pos_d  = '0;
          if (byte_i == '0) begin
            if (cfg_i.listen) begin
              res_o[0].kind = KIND_DONE;
              res_cnt_o     = 2'd1;
            end
            phase_d = PH_OPCODE;
            pend_d  = PEND_NONE;
          end else begin
            phase_d = PH_ENTRY;
          end
        end
      end
      PH_ENTRY: begin
        if ((pos_q == '0) && (byte_i > MaxAddrType)) begin
          res_o[0].kind        = KIND_BADTYPE;
          res_o[0].entry_index = num_q;
          res_cnt_o            = 2'd1;
          pend_d               = PEND_NONE;
          phase_d              = last_i ? PH_OPCODE : PH_DROP;
          pos_d                = '0;
        end else begin
          type_d = cur_type;
          len_d  = cur_len;
          if (cfg_i.listen) begin
            res_o[0].kind         = KIND_ENTRY;
            res_o[0].payload      = byte_i;
            res_o[0].entry_index  = num_q;
            res_o[0].entry_offset = pos_q;
            res_o[0].entry_type   = cur_type;
            res_cnt_o             = 2'd1;
          end
          pos_d = pos_inc;
          if (pos_inc >= cur_len) begin
            pos_d  = '0;
            num_d  = num_q + ByteW'(1);
            left_d = left_dec;
            if (left_dec == '0) begin
              if (cfg_i.listen) begin
                res_o[1].kind = KIND_DONE;
                res_cnt_o     = 2'd2;
              end
              phase_d = PH_OPCODE;
              pend_d  = PEND_NONE;
            end
          end
        end
      end
      PH_DROP: begin
        if (last_i) begin
          phase_d = PH_OPCODE;
          pend_d  = PEND_NONE;
        end
      end
      default: begin
        phase_d = PH_OPCODE;
        pend_d  = PEND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      pend_q  <= PEND_NONE;
      left_q  <= '0;
      num_q   <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      left_q  <= left_d;
      num_q   <= num_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      type_q  <= type_d;
    end
  end

endmodule

FILE: hdl/plrd_result_buf.sv
// ----------------------------------------------------------------------------
// plrd_result_buf: result group register and output drain
// Holds the results of one byte and hands them out one word per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module plrd_result_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  plrd_pkg::result_t             res_i [plrd_pkg::MaxRes],
  input  logic [plrd_pkg::ResCntW-1:0]  res_cnt_i,
  output logic                          free_o,
  output plrd_pkg::result_t             out_o,
  output logic                          out_valid_o,
  output logic                          out_last_o,
  input  logic                          out_ready_i
);
  import plrd_pkg::*;

  result_t             res_q [MaxRes];
  logic [ResCntW-1:0]  cnt_q;
  logic [ResCntW-1:0]  ptr_q;
  logic                take, group_done;

  always_comb begin
    out_valid_o = (cnt_q != '0);
    out_last_o  = (ptr_q == cnt_q - ResCntW'(1));
    take        = out_valid_o && out_ready_i;
    group_done  = take && out_last_o;
    free_o      = !out_valid_o || group_done;
    case (ptr_q)
      2'd0:    out_o = res_q[0];
      2'd1:    out_o = res_q[1];
      2'd2:    out_o = res_q[2];
      default: out_o = ResultZero;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < MaxRes; i++) begin
        res_q[i] <= res_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_cnt_i;
      ptr_q <= '0;
    end else if (group_done) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else if (take) begin
      ptr_q <= ptr_q + ResCntW'(1);
    end
  end

endmodule

FILE: hdl/player_list_reply_deframer.sv
// ----------------------------------------------------------------------------
// player_list_reply_deframer: server stream framer for player lists
// Frames opcode/count messages, answers port extension requests and emits
// player list entry bytes with their position.
// ----------------------------------------------------------------------------
// Received bytes enter a one-word input register; the framing core decodes
// the registered byte against its state and loads up to three results into a
// result group register that drives the output stream. A byte that yields no
// result or one result is taken every cycle while the output is ready, so the
// stream runs at one byte per clock through the input and result group
// registers. A byte that yields several results (a port extension reply gives
// three words, the last byte of the last list entry with the listener on gives
// the entry byte and the complete event) occupies the single output port until
// its words are out, and the next byte waits in the input register until the
// group drains. Each output word carries tlast on the last result of its input
// byte and its kind in tuser. Configuration writes are always ready and take
// effect on the next cycle; write them only while the block is idle.
// ----------------------------------------------------------------------------
module player_list_reply_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  input  logic                          s_axis_tlast,   // chunk_last
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [plrd_pkg::MDataW-1:0]   m_axis_tdata,   // [7:0] payload,
                                                        // [15:8] entry_index,
                                                        // [20:16] entry_offset,
                                                        // [22:21] entry_type, [23] zero
  output logic [plrd_pkg::KindW-1:0]    m_axis_tuser,   // [2:0] kind
  output logic                          m_axis_tlast,   // run_last
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [plrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [plrd_pkg::PortW-1:0]    cfg_data_i
);
  import plrd_pkg::*;

  cfg_t               cfg;
  logic               in_vld_q;
  logic [ByteW-1:0]   in_byte_q;
  logic               in_last_q;
  logic               fire;
  logic               buf_free;
  result_t            core_res [MaxRes];
  logic [ResCntW-1:0] core_cnt;
  result_t            out_res;

  assign cfg_ready_o = 1'b1;

  plrd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the registered byte once its results have somewhere to go.
  assign fire          = in_vld_q && ((core_cnt == '0) || buf_free);
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // Hold the input word while it waits on the result group.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  plrd_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .take_i    (fire),
    .res_o     (core_res),
    .res_cnt_o (core_cnt)
  );

  plrd_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && (core_cnt != '0)),
    .res_i       (core_res),
    .res_cnt_i   (core_cnt),
    .free_o      (buf_free),
    .out_o       (out_res),
    .out_valid_o (m_axis_tvalid),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {1'b0, out_res.entry_type, out_res.entry_offset,
                         out_res.entry_index, out_res.payload};

endmodule

FILE: tb/tb_player_list_reply_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_player_list_reply_deframer: self-checking bench of the reply deframer
// Feeds framed server messages (port extension requests, player lists, bad
// opcodes, bad address types, noise) under bursty input and a stalling
// output, and checks every output word against a cycle-free model of the
// framing state.
// ----------------------------------------------------------------------------
module tb_player_list_reply_deframer;
  import plrd_pkg::*;

  localparam int unsigned DrainCycles = 8;       // pipeline depth plus margin
  localparam int unsigned CycleLimit  = 200000;  // timeout for the whole run
  localparam int unsigned PhaseBytes  = 40;      // random bytes per config phase

  // One output word as the bench sees it: all fields plus tlast.
  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   payload;
    logic [ByteW-1:0]   entry_index;
    logic [OffsetW-1:0] entry_offset;
    logic [TypeW-1:0]   entry_type;
    logic               run_last;
  } deframe_word_t;

  // Scoreboard: mirrors the configuration and the framing state, turns each
  // accepted byte into its expected output words, and checks words in order.
  class deframe_scoreboard;
    logic [ByteW-1:0]   op_port_ext;
    logic [ByteW-1:0]   op_player_list;
    logic [PortW-1:0]   local_port;
    logic               listen;
    phase_e             phase;
    pend_e              pend;
    logic [ByteW-1:0]   entries_left;
    logic [ByteW-1:0]   entry_number;
    logic [OffsetW-1:0] byte_pos;
    logic [OffsetW-1:0] entry_len;
    logic [TypeW-1:0]   cur_type;
    deframe_word_t      expected_words[$];
    int unsigned        errors;

    function new();
      op_port_ext    = 8'd0;
      op_player_list = 8'd1;
      local_port     = '0;
      listen         = 1'b0;
      phase          = PH_OPCODE;
      pend           = PEND_NONE;
      entries_left   = '0;
      entry_number   = '0;
      byte_pos       = '0;
      entry_len      = '0;
      cur_type       = '0;
      errors         = 0;
    endfunction

    function void apply_reg(reg_idx_e idx, logic [PortW-1:0] data);
      case (idx)
        REG_OP_PORT_EXT:    op_port_ext    = data[ByteW-1:0];
        REG_OP_PLAYER_LIST: op_player_list = data[ByteW-1:0];
        REG_LOCAL_PORT:     local_port     = data;
        default:            listen         = data[0];
      endcase
    endfunction

    function int unsigned pending_words();
      return expected_words.size();
    endfunction

    function void push_word(kind_e k, logic [ByteW-1:0] p, logic [ByteW-1:0] idx,
                            logic [OffsetW-1:0] off, logic [TypeW-1:0] t);
      deframe_word_t w;
      w.kind         = k;
      w.payload      = p;
      w.entry_index  = idx;
      w.entry_offset = off;
      w.entry_type   = t;
      w.run_last     = 1'b0;
      expected_words = {expected_words, w};
    endfunction

    function void restart_framing();
      phase = PH_OPCODE;
      pend  = PEND_NONE;
    endfunction

    function void note_rx_byte(logic [ByteW-1:0] b, logic chunk_last);
      int unsigned first;
      logic        v4;
      logic        port_present;
      logic        type_ok;
      first   = expected_words.size();
      type_ok = 1'b1;
      case (phase)
        PH_OPCODE: begin
          // port extension wins when both opcodes are equal
          if (b == op_port_ext) begin
            pend  = PEND_PORT_EXT;
            phase = PH_COUNT;
          end else if (b == op_player_list) begin
            pend  = PEND_LIST;
            phase = PH_COUNT;
          end else begin
            push_word(KIND_BADOP, '0, '0, '0, '0);
            pend  = PEND_NONE;
            phase = chunk_last ? PH_OPCODE : PH_DROP;
          end
        end
        PH_COUNT: begin
          if (pend == PEND_PORT_EXT) begin
            if (b != '0) begin
              push_word(KIND_REPLY, op_port_ext, '0, '0, '0);
              push_word(KIND_REPLY, local_port[15:8], '0, '0, '0);
              push_word(KIND_REPLY, local_port[7:0], '0, '0, '0);
            end
            restart_framing();
          end else begin
            entries_left = b;
            entry_number = '0;
            byte_pos     = '0;
            if (b == '0) begin
              if (listen) push_word(KIND_DONE, '0, '0, '0, '0);
              restart_framing();
            end else begin
              phase = PH_ENTRY;
            end
          end
        end
        PH_ENTRY: begin
          if (byte_pos == '0) begin
            if (b > MaxAddrType) begin
              push_word(KIND_BADTYPE, '0, entry_number, '0, '0);
              restart_framing();
              phase    = chunk_last ? PH_OPCODE : PH_DROP;
              byte_pos = '0;
              type_ok  = 1'b0;
            end else begin
              v4           = (b == 8'd1) || (b == 8'd2);
              port_present = (b == 8'd2) || (b == 8'd3);
              cur_type     = b[TypeW-1:0];
              entry_len    = LenTypeByte + (v4 ? LenAddrV4 : LenAddrV6) +
                             (port_present ? LenPort : 5'd0);
            end
          end
          if (type_ok) begin
            if (listen) push_word(KIND_ENTRY, b, entry_number, byte_pos, cur_type);
            byte_pos = byte_pos + 5'd1;
            if (byte_pos >= entry_len) begin
              byte_pos     = '0;
              entry_number = entry_number + 8'd1;
              entries_left = entries_left - 8'd1;
              if (entries_left == '0) begin
                if (listen) push_word(KIND_DONE, '0, '0, '0, '0);
                restart_framing();
              end
            end
          end
        end
        default: begin
          // drop until the chunk ends
          if (chunk_last) restart_framing();
        end
      endcase
      if (expected_words.size() > first)
        expected_words[expected_words.size()-1].run_last = 1'b1;
    endfunction

    task report_mismatch(string field, int unsigned got, int unsigned want);
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got,
               want);
      errors++;
    endtask

    task check_out_word(deframe_word_t got);
      deframe_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word (kind)", got.kind, 0);
        return;
      end
      want = expected_words.pop_front();
      if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
      if (got.payload != want.payload) report_mismatch("payload", got.payload, want.payload);
      if (got.entry_index != want.entry_index)
        report_mismatch("entry_index", got.entry_index, want.entry_index);
      if (got.entry_offset != want.entry_offset)
        report_mismatch("entry_offset", got.entry_offset, want.entry_offset);
      if (got.entry_type != want.entry_type)
        report_mismatch("entry_type", got.entry_type, want.entry_type);
      if (got.run_last != want.run_last)
        report_mismatch("run_last", got.run_last, want.run_last);
    endtask
  endclass

  // DUT signals; every input is known from time zero.
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata   = '0;
  logic                s_axis_tlast   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [MDataW-1:0]   m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [PortW-1:0]    cfg_data_i     = '0;

  deframe_scoreboard   sb;
  int unsigned         cycle_count    = 0;
  int unsigned         sent_bytes     = 0;
  int unsigned         burst_left     = 1;
  int unsigned         rx_mode        = 0;
  int unsigned         rx_mode_left   = 0;

  player_list_reply_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Timeout: a hung handshake or a missing word ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: hold one stall pattern for a stretch of cycles, then switch.
  // Mode 0 never stalls, 1 and 2 stall at random (light and heavy), 3 drops
  // ready whenever the cycle count modulo 4 is 3.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 120);
    end else begin
      rx_mode_left = rx_mode_left - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
      2:       m_axis_tready <= ($urandom_range(0, 9) < 3);
      default: m_axis_tready <= ((cycle_count % 4) != 3);
    endcase
  end

  // Input monitor: every accepted byte feeds the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_rx_byte(s_axis_tdata, s_axis_tlast);
  end

  // Output monitor: unpack the word and check it against the oldest expectation.
  always @(posedge clk_i) begin
    deframe_word_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind         = kind_e'(m_axis_tuser);
      got.payload      = m_axis_tdata[7:0];
      got.entry_index  = m_axis_tdata[15:8];
      got.entry_offset = m_axis_tdata[20:16];
      got.entry_type   = m_axis_tdata[22:21];
      got.run_last     = m_axis_tlast;
      sb.check_out_word(got);
    end
  end

  function automatic logic rand_last();
    return ($urandom_range(0, 9) == 0);
  endfunction

  // Send one byte. Keep tvalid high across a burst; at the end of a burst
  // drop it for a random gap and pick the next burst length.
  task automatic send_byte(input logic [7:0] b, input logic chunk_last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= chunk_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_bytes = sent_bytes + 1;
    burst_left = burst_left - 1;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
    end
  endtask

  // Wait until every predicted word is out, then let the pipeline flush any
  // byte that produced nothing.
  task automatic wait_idle();
    while (sb.pending_words() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write; keep cfg_valid_i high when another write follows.
  task automatic cfg_write(input reg_idx_e idx, input logic [PortW-1:0] data,
                           input logic final_write);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.apply_reg(idx, data);
    if (final_write) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] op_ext, input logic [7:0] op_list,
                            input logic [15:0] port, input logic listen);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    cfg_write(REG_OP_PORT_EXT, {8'd0, op_ext}, 1'b0);
    cfg_write(REG_OP_PLAYER_LIST, {8'd0, op_list}, 1'b0);
    cfg_write(REG_LOCAL_PORT, port, 1'b0);
    cfg_write(REG_LISTENER, {15'd0, listen}, 1'b1);
  endtask

  // Abort byte followed by a few dropped bytes and a chunk end. Sometimes the
  // abort byte ends the chunk itself, so nothing is dropped.
  task automatic send_abort(input logic [7:0] bad);
    int unsigned n;
    if ($urandom_range(0, 3) == 0) begin
      send_byte(bad, 1'b1);
    end else begin
      send_byte(bad, 1'b0);
      n = $urandom_range(0, 4);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // One random message. Mostly well-formed lists and port extension requests
  // with random content; the rest are aborts and stray bytes.
  task automatic send_random_message();
    int unsigned choice;
    int unsigned count;
    int unsigned body_len;
    logic [7:0]  b;
    logic [7:0]  etype;
    logic        same_ops;
    choice   = $urandom_range(0, 99);
    same_ops = (sb.op_port_ext == sb.op_player_list);
    if (choice < 40 && !same_ops) begin
      send_byte(sb.op_player_list, rand_last());
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
      send_byte(8'(count), rand_last());
      for (int e = 0; e < count; e++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_abort(8'($urandom_range(4, 255)));
          return;
        end
        etype    = 8'($urandom_range(0, 3));
        body_len = ((etype == 8'd1 || etype == 8'd2) ? 4 : 16) +
                   ((etype == 8'd2 || etype == 8'd3) ? 2 : 0);
        send_byte(etype, rand_last());
        repeat (body_len) send_byte(8'($urandom_range(0, 255)), rand_last());
      end
    end else if (choice < 65) begin
      send_byte(sb.op_port_ext, rand_last());
      send_byte(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)), rand_last());
    end else if (choice < 75) begin
      send_byte(sb.op_player_list, rand_last());
      send_byte(8'd0, rand_last());
    end else if (choice < 90) begin
      b = 8'($urandom_range(0, 255));
      while (b == sb.op_port_ext || b == sb.op_player_list) b = 8'($urandom_range(0, 255));
      send_abort(b);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random_phase(input int unsigned target);
    int unsigned start;
    start = sent_bytes;
    while (sent_bytes - start < target) send_random_message();
  endtask

  initial begin
    logic [7:0] op_a;
    logic [7:0] op_b;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset opcodes, a port with both byte halves distinct.
    set_config(8'd0, 8'd1, 16'hA55A, 1'b1);
    // port extension with a nonzero count: three reply words
    send_byte(8'd0, 1'b0);
    send_byte(8'd5, 1'b0);
    // port extension with a zero count: no reply
    send_byte(8'd0, 1'b0);
    send_byte(8'd0, 1'b0);
    // empty list: complete event at once
    send_byte(8'd1, 1'b0);
    send_byte(8'd0, 1'b0);
    // unknown opcode on the chunk's last byte: next byte is an opcode again
    send_byte(8'h7F, 1'b1);
    // unknown opcode mid-chunk: drop everything up to the chunk end
    send_byte(8'hFF, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'h55, 1'b1);
    // one IPv4 entry with port; switch the listener off halfway through, so
    // the tail bytes and the complete event are suppressed
    send_byte(8'd1, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    cfg_write(REG_LISTENER, 16'd0, 1'b1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    // bad address type on the chunk's last byte, then a fresh opcode
    send_byte(8'd1, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'd4, 1'b1);

    // Random phases over extreme, equal and random register settings.
    set_config(8'hFF, 8'h00, 16'hFFFF, 1'b1);
    run_random_phase(PhaseBytes);

    op_a = 8'($urandom_range(0, 255));
    set_config(op_a, op_a, 16'h0000, 1'b1);
    run_random_phase(PhaseBytes);

    op_a = 8'($urandom_range(0, 255));
    op_b = 8'($urandom_range(0, 255));
    while (op_b == op_a) op_b = 8'($urandom_range(0, 255));
    set_config(op_a, op_b, 16'($urandom_range(0, 65535)), 1'b0);
    run_random_phase(PhaseBytes);

    op_a = 8'($urandom_range(0, 255));
    op_b = 8'($urandom_range(0, 255));
    while (op_b == op_a) op_b = 8'($urandom_range(0, 255));
    set_config(op_a, op_b, 16'($urandom_range(0, 65535)), 1'b1);
    run_random_phase(PhaseBytes);

    // Drain and decide.
    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
